// File: src/perrd_pkg.sv
`timescale 1ns / 1ps
// perrd_pkg: shared constants, codes and structs of the pending-event dispatcher
// no dependencies

package perrd_pkg;

  localparam int NUM_SOURCES   = 14;
  localparam int COUNT_WIDTH   = 16;
  localparam int TOTAL_W       = 20;
  localparam int SRC_W         = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;
  localparam int ISS_W         = $clog2(NUM_SOURCES + 1);
  localparam int CMP_W         = (COUNT_WIDTH > TOTAL_W) ? COUNT_WIDTH : TOTAL_W;
  localparam int COLLECTOR_IDX = NUM_SOURCES - 1;

  localparam logic [COUNT_WIDTH-1:0] CNT_MAX   = '1;
  localparam logic [TOTAL_W-1:0]     TOTAL_MAX = '1;
  localparam logic [SRC_W-1:0]       LAST_IDX  = SRC_W'(NUM_SOURCES - 1);

  localparam logic [1:0] REQ_ARRIVAL   = 2'd0;
  localparam logic [1:0] REQ_COLLECTOR = 2'd1;
  localparam logic [1:0] REQ_DISPATCH  = 2'd2;
  localparam logic [1:0] REQ_DONE      = 2'd3;

  localparam logic [2:0] ACT_COUNTED  = 3'd0;
  localparam logic [2:0] ACT_ABORT    = 3'd1;
  localparam logic [2:0] ACT_TRAP     = 3'd2;
  localparam logic [2:0] ACT_DISPATCH = 3'd3;
  localparam logic [2:0] ACT_NONE     = 3'd4;
  localparam logic [2:0] ACT_IGNORED  = 3'd5;

  localparam logic REG_MASK_ALL     = 1'b0;
  localparam logic REG_COLLECTOR_EN = 1'b1;

  typedef struct packed {
    logic mask_all;
    logic collector_enable;
  } cfg_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic [3:0] source;
    logic       in_managed;
    logic       io_waiting;
  } req_t;

  typedef struct packed {
    logic [2:0]         action;
    logic [3:0]         served_source;
    logic [15:0]        served_count;
    logic [TOTAL_W-1:0] total_pending;
  } res_t;

endpackage

// File: src/pending_event_round_robin_dispatcher_unit.sv
`timescale 1ns / 1ps
// arrival and collector items pass the count read, S_UPD, S_OUT and the output register; done and
// ignored items go straight to S_OUT; a dispatch scans from the source after the last served one
// one request in the sequencer at a time; rate set by the single count memory:
// one read-modify-write per arrival, one read per cycle while the dispatch scan walks the sources
// reset: rst_n synchronous; clears control state and the per-entry valid flags at once,
// so the count memory reads as zero with no clearing pass
// depends on perrd_pkg and perrd_seq

module pending_event_round_robin_dispatcher_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic                           cfg_index,
  input  logic                           cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [1:0]                     in_req_type,
  input  logic [3:0]                     in_source,
  input  logic                           in_managed,
  input  logic                           in_io_waiting,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [2:0]                     out_action,
  output logic [3:0]                     out_served_source,
  output logic [15:0]                    out_served_count,
  output logic [perrd_pkg::TOTAL_W-1:0]  out_total_pending
);
  import perrd_pkg::*;

  cfg_t cfg_r, cfg_nxt;
  req_t req;
  res_t res, out_res_r;
  logic res_valid, res_ready;
  logic out_valid_r, out_valid_nxt;

  assign req = '{in_req_type, in_source, in_managed, in_io_waiting};

  perrd_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .req_valid (in_valid),
    .req_ready (in_ready),
    .req       (req),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_MASK_ALL:     cfg_nxt.mask_all = cfg_wdata;
        REG_COLLECTOR_EN: cfg_nxt.collector_enable = cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // output register parts the sequencer from the consumer
  assign res_ready = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cfg_r       <= cfg_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res_r <= res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_action        = out_res_r.action;
  assign out_served_source = out_res_r.served_source;
  assign out_served_count  = out_res_r.served_count;
  assign out_total_pending = out_res_r.total_pending;

endmodule

// File: src/perrd_ram.sv
`timescale 1ns / 1ps
// perrd_ram: generic simple dual-port ram, one write port, one registered read port
// no dependencies

module perrd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                                      clk,
  input  logic                                      wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                          wr_data,
  input  logic                                      rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                          rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: src/perrd_seq.sv
`timescale 1ns / 1ps
// perrd_seq: request sequencer, read-modify-write of the count memory and round-robin scan
// depends on perrd_pkg and perrd_ram

module perrd_seq (
  input  logic            clk,
  input  logic            rst_n,
  input  perrd_pkg::cfg_t cfg,
  input  logic            req_valid,
  output logic            req_ready,
  input  perrd_pkg::req_t req,
  output logic            res_valid,
  input  logic            res_ready,
  output perrd_pkg::res_t res
);
  import perrd_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_UPD  = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic [1:0]             state_r, state_nxt;
  logic [SRC_W-1:0]       last_served_r, last_served_nxt;
  logic [TOTAL_W-1:0]     total_r, total_nxt;
  logic                   trap_pending_r, trap_pending_nxt;
  logic                   in_handler_r, in_handler_nxt;
  logic [NUM_SOURCES-1:0] vld_r;
  logic [SRC_W-1:0]       cur_idx_r, cur_idx_nxt;
  logic [SRC_W-1:0]       scan_idx_r, scan_idx_nxt;
  logic [ISS_W-1:0]       issued_r, issued_nxt;
  logic                   chk_valid_r, chk_valid_nxt;
  logic                   is_coll_r, is_coll_nxt;
  logic                   managed_r, managed_nxt;
  logic                   iowait_r, iowait_nxt;
  res_t                   res_r, res_nxt;

  logic                   rd_en, wr_en, found;
  logic [SRC_W-1:0]       rd_addr;
  logic [COUNT_WIDTH-1:0] rd_data, cnt_rd, cnt_upd;
  logic                   cnt_sat;
  logic [TOTAL_W-1:0]     total_inc, total_dec;

  perrd_ram #(
    .WIDTH (COUNT_WIDTH),
    .DEPTH (NUM_SOURCES)
  ) u_count_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (cur_idx_r),
    .wr_data (cnt_upd),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // entries never written read as zero
  assign cnt_rd    = vld_r[cur_idx_r] ? rd_data : '0;
  assign cnt_sat   = (cnt_rd == CNT_MAX);
  assign total_inc = (total_r == TOTAL_MAX) ? total_r : total_r + 1'b1;
  assign total_dec = (CMP_W'(total_r) > CMP_W'(cnt_rd))
                   ? TOTAL_W'(CMP_W'(total_r) - CMP_W'(cnt_rd)) : '0;

  assign req_ready = (state_r == S_IDLE);
  assign res_valid = (state_r == S_OUT);
  assign res       = res_r;

  always_comb begin
    state_nxt        = state_r;
    last_served_nxt  = last_served_r;
    total_nxt        = total_r;
    trap_pending_nxt = trap_pending_r;
    in_handler_nxt   = in_handler_r;
    cur_idx_nxt      = cur_idx_r;
    scan_idx_nxt     = scan_idx_r;
    issued_nxt       = issued_r;
    chk_valid_nxt    = 1'b0;
    is_coll_nxt      = is_coll_r;
    managed_nxt      = managed_r;
    iowait_nxt       = iowait_r;
    res_nxt          = res_r;
    rd_en            = 1'b0;
    rd_addr          = scan_idx_r;
    wr_en            = 1'b0;
    cnt_upd          = '0;
    found            = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (req_valid) begin
          managed_nxt = req.in_managed;
          iowait_nxt  = req.io_waiting;
          case (req.req_type)
            REQ_ARRIVAL: begin
              if (int'(req.source) >= COLLECTOR_IDX) begin
                res_nxt   = '{ACT_IGNORED, 4'd0, 16'd0, total_r};
                state_nxt = S_OUT;
              end else begin
                rd_en       = 1'b1;
                rd_addr     = SRC_W'(req.source);
                cur_idx_nxt = SRC_W'(req.source);
                is_coll_nxt = 1'b0;
                state_nxt   = S_UPD;
              end
            end
            REQ_COLLECTOR: begin
              if (cfg.collector_enable) begin
                rd_en       = 1'b1;
                rd_addr     = LAST_IDX;
                cur_idx_nxt = LAST_IDX;
                is_coll_nxt = 1'b1;
                state_nxt   = S_UPD;
              end else begin
                res_nxt   = '{ACT_IGNORED, 4'd0, 16'd0, total_r};
                state_nxt = S_OUT;
              end
            end
            REQ_DISPATCH: begin
              scan_idx_nxt = (last_served_r == LAST_IDX) ? '0 : last_served_r + 1'b1;
              issued_nxt   = '0;
              state_nxt    = S_SCAN;
            end
            default: begin
              in_handler_nxt = 1'b0;
              res_nxt        = '{ACT_COUNTED, 4'd0, 16'd0, total_r};
              state_nxt      = S_OUT;
            end
          endcase
        end
      end
      S_UPD: begin
        wr_en     = 1'b1;
        cnt_upd   = cnt_sat ? cnt_rd : cnt_rd + 1'b1;
        total_nxt = cnt_sat ? total_r : total_inc;
        res_nxt   = '{ACT_COUNTED, 4'd0, 16'd0, total_nxt};
        if (!is_coll_r && !cfg.mask_all) begin
          if (iowait_r) begin
            res_nxt.action = ACT_ABORT;
          end else if (managed_r && !trap_pending_r && !in_handler_r) begin
            trap_pending_nxt = 1'b1;
            res_nxt.action   = ACT_TRAP;
          end
        end
        state_nxt = S_OUT;
      end
      S_SCAN: begin
        // one read issued per cycle, its data checked in the cycle after
        if (chk_valid_r && (cnt_rd != '0)) begin
          found            = 1'b1;
          wr_en            = 1'b1;
          cnt_upd          = '0;
          total_nxt        = total_dec;
          last_served_nxt  = cur_idx_r;
          trap_pending_nxt = 1'b0;
          in_handler_nxt   = 1'b1;
          res_nxt          = '{ACT_DISPATCH, 4'(cur_idx_r), 16'(cnt_rd), total_dec};
          state_nxt        = S_OUT;
        end else if (issued_r < ISS_W'(NUM_SOURCES)) begin
          rd_en         = 1'b1;
          cur_idx_nxt   = scan_idx_r;
          chk_valid_nxt = 1'b1;
          scan_idx_nxt  = (scan_idx_r == LAST_IDX) ? '0 : scan_idx_r + 1'b1;
          issued_nxt    = issued_r + 1'b1;
        end else if (!chk_valid_r) begin
          res_nxt   = '{ACT_NONE, 4'd0, 16'd0, total_r};
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      last_served_r  <= '0;
      total_r        <= '0;
      trap_pending_r <= 1'b0;
      in_handler_r   <= 1'b0;
      vld_r          <= '0;
      issued_r       <= '0;
      chk_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      last_served_r  <= last_served_nxt;
      total_r        <= total_nxt;
      trap_pending_r <= trap_pending_nxt;
      in_handler_r   <= in_handler_nxt;
      issued_r       <= issued_nxt;
      chk_valid_r    <= chk_valid_nxt;
      if (wr_en) begin
        vld_r[cur_idx_r] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur_idx_r  <= cur_idx_nxt;
    scan_idx_r <= scan_idx_nxt;
    is_coll_r  <= is_coll_nxt;
    managed_r  <= managed_nxt;
    iowait_r   <= iowait_nxt;
    res_r      <= res_nxt;
  end

  a_wr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (int'(cur_idx_r) < NUM_SOURCES))
    else $error("count write outside the source range");

  a_upd_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_UPD) |-> $past(rd_en))
    else $error("update without a preceding count read");

  a_dispatch_enters_handler: assert property (@(posedge clk) disable iff (!rst_n)
    found |=> (in_handler_r && !trap_pending_r && (last_served_r == $past(cur_idx_r))))
    else $error("dispatch did not update handler state");

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    int'(issued_r) <= NUM_SOURCES)
    else $error("scan issued more reads than sources");

endmodule
